// ===== rtl/alids_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alids_pkg: shared types and constants of the ordered list store
// request codes, fixed field widths and default sizes
// ----------------------------------------------------------------------------
package alids_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 8;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the request and result ports
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int FIDX_W  = 3;
	localparam int COUNT_W = 4;

	typedef logic [1:0] op_t;

	// request codes
	localparam op_t OP_INSERT   = 2'd0;
	localparam op_t OP_DELETE   = 2'd1;
	localparam op_t OP_LOCATE   = 2'd2;
	localparam op_t OP_RETRIEVE = 2'd3;

endpackage

// ===== rtl/alids_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alids_ram: entry storage of the ordered list store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module alids_ram #(
	parameter int DEPTH      = alids_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = alids_pkg::DATA_WIDTH_DEF,
	parameter int AW         = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);
	import alids_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/array_list_insert_delete_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search: fixed-depth ordered list store
// insert, delete, locate by value and retrieve by position over one memory
// ----------------------------------------------------------------------------
// a failed request finishes without a memory access; a retrieve reads a single entry;
//   insert and delete walk the entries they move, and a locate walks until a hit
//   or the end of the list
// throughput: one transaction at a time; busy stays high until the result
//   cycle, and a new start is taken in that same result cycle
// cost per request is set by the one read port of the memory: one entry moved or
//   compared per cycle, plus the drain of the registered read
// reset: arst_n clears the entry count and the sequencer; entries are not cleared
// results cannot be stalled: each result is shown for exactly one cycle with done
// ----------------------------------------------------------------------------
module array_list_insert_delete_search #(
	parameter int DEPTH      = alids_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = alids_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  alids_pkg::op_t                      op,
	input  logic signed [alids_pkg::VALUE_W-1:0] value,
	input  logic [alids_pkg::POS_W-1:0]         position,
	output logic                                done,
	output logic                                ok,
	output logic [alids_pkg::FIDX_W-1:0]        found_index,
	output logic signed [alids_pkg::VALUE_W-1:0] read_value,
	output logic [alids_pkg::COUNT_W-1:0]       count
);
	import alids_pkg::*;

	// index and count widths follow from the depth
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// sequencer codes
	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic state_q, state_n;

	// request registers
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [CW-1:0]         pos_q;     // target position, clamped to the count for an insert
	logic                  fail_q;    // request rejected at accept

	// walk registers: index and the read in flight
	logic [CW-1:0] idx_q, idx_n;
	logic          pend_q, pend_n;
	logic [CW-1:0] paddr_q, paddr_n;   // write target or compared position

	logic [CW-1:0] cnt_q, cnt_n;

	// result registers
	logic                  done_q, done_n;
	logic                  ok_q, ok_n;
	logic [CW-1:0]         fidx_q, fidx_n;
	logic [DATA_WIDTH-1:0] rval_q, rval_n;

	// memory port
	logic                  we;
	logic [CW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [CW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;

	// shared step unit: one increment, one decrement and a bound compare chosen by the request
	logic [CW-1:0] idx_inc, idx_dec;
	logic          more;

	logic                  accept;
	logic [CMPW-1:0]       pos_w, cnt_w;
	logic                  pos_lt_cnt;
	logic [DATA_WIDTH-1:0] dmin;

	assign accept     = start && (state_q == S_IDLE);
	assign pos_w      = CMPW'(position);
	assign cnt_w      = CMPW'(cnt_q);
	assign pos_lt_cnt = pos_w < cnt_w;
	assign dmin       = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	assign idx_inc = idx_q + 1'b1;
	assign idx_dec = idx_q - 1'b1;
	// insert walks down toward the target, the others walk up to the count
	assign more    = (op_q == OP_INSERT) ? (idx_q > pos_q) : (idx_q < cnt_q);

	alids_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr[AW-1:0]),
		.rdata (rdata)
	);

	// request capture; fail checks and the starting index are settled here
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= DATA_WIDTH'(value);
			unique case (op)
				OP_INSERT: begin
					fail_q <= (cnt_q == CW'(DEPTH));
					pos_q  <= pos_lt_cnt ? CW'(position) : cnt_q;
					idx_q  <= cnt_q;
				end
				OP_DELETE: begin
					fail_q <= !pos_lt_cnt;
					pos_q  <= CW'(position);
					idx_q  <= CW'(position) + 1'b1;
				end
				OP_LOCATE: begin
					fail_q <= 1'b0;
					pos_q  <= '0;
					idx_q  <= '0;
				end
				default: begin
					fail_q <= !pos_lt_cnt;
					pos_q  <= CW'(position);
					idx_q  <= CW'(position);
				end
			endcase
		end else if (state_q == S_RUN) begin
			idx_q <= idx_n;
		end
	end

	// sequencer: one memory read and at most one write each cycle
	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		pend_n  = 1'b0;
		paddr_n = paddr_q;
		cnt_n   = cnt_q;
		done_n  = 1'b0;
		ok_n    = 1'b0;
		fidx_n  = '0;
		rval_n  = '0;
		we      = 1'b0;
		waddr   = paddr_q;
		wdata   = rdata;
		raddr   = (op_q == OP_INSERT) ? idx_dec : idx_q;

		if (state_q == S_RUN) begin
			if (fail_q) begin
				state_n = S_IDLE;
				done_n  = 1'b1;
				if (op_q == OP_RETRIEVE) begin
					rval_n = dmin;
				end
			end else begin
				case (op_q)
					OP_INSERT: begin
						// move entry idx-1 up; its registered read data is written in the next cycle
						we = pend_q;
						if (more) begin
							idx_n   = idx_dec;
							pend_n  = 1'b1;
							paddr_n = idx_q;
						end
						if (!pend_q && !more) begin
							we      = 1'b1;
							waddr   = pos_q;
							wdata   = key_q;
							cnt_n   = cnt_q + 1'b1;
							ok_n    = 1'b1;
							done_n  = 1'b1;
							state_n = S_IDLE;
						end
					end
					OP_DELETE: begin
						// move entry idx down over the removed one
						we = pend_q;
						if (more) begin
							idx_n   = idx_inc;
							pend_n  = 1'b1;
							paddr_n = idx_dec;
						end
						if (!pend_q && !more) begin
							cnt_n   = cnt_q - 1'b1;
							ok_n    = 1'b1;
							done_n  = 1'b1;
							state_n = S_IDLE;
						end
					end
					OP_LOCATE: begin
						if (pend_q && (rdata == key_q)) begin
							ok_n    = 1'b1;
							fidx_n  = paddr_q;
							done_n  = 1'b1;
							state_n = S_IDLE;
						end else if (more) begin
							idx_n   = idx_inc;
							pend_n  = 1'b1;
							paddr_n = idx_q;
						end else if (!pend_q) begin
							// walked the whole list without a hit
							done_n  = 1'b1;
							state_n = S_IDLE;
						end
					end
					default: begin
						if (pend_q) begin
							ok_n    = 1'b1;
							rval_n  = rdata;
							done_n  = 1'b1;
							state_n = S_IDLE;
						end else begin
							pend_n = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= accept ? S_RUN : state_n;
			pend_q  <= accept ? 1'b0 : pend_n;
			cnt_q   <= cnt_n;
			done_q  <= done_n;
		end
	end

	// result payload, held until the next transaction finishes
	always_ff @(posedge clk) begin
		paddr_q <= paddr_n;
		if (done_n) begin
			ok_q   <= ok_n;
			fidx_q <= fidx_n;
			rval_q <= rval_n;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign ok          = ok_q;
	assign found_index = FIDX_W'(fidx_q);
	assign read_value  = signed'(VALUE_W'(rval_q));
	assign count       = COUNT_W'(cnt_q);

	// the result strobe always lands with the sequencer back at rest
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
	else $error("result strobe while sequencer running");

	// the entry count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
	else $error("entry count beyond depth");

	// a successful insert grows the list by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ok_q && (op_q == OP_INSERT)) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)))
	else $error("insert did not grow count by one");

	// a successful delete shrinks the list by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ok_q && (op_q == OP_DELETE)) |-> (cnt_q == CW'($past(cnt_q) - 1'b1)))
	else $error("delete did not shrink count by one");

	// a failed request leaves the count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !ok_q) |-> $stable(cnt_q))
	else $error("failed request changed count");

endmodule

// ===== verif/array_list_insert_delete_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_tb: self-checking bench for the list store
// drives insert, delete, locate and retrieve requests with random gaps, keeps a
// shadow copy of the list to predict each result and checks every done strobe
// ----------------------------------------------------------------------------
module array_list_insert_delete_search_tb;

	import alids_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CLK_HALF    = 2;
	localparam int RESET_CYCS  = 8;
	localparam int RANDOM_REQS = 1450;
	localparam int MAX_PRINTS  = 40;

	// one request as driven on the ports, plus the idle cycles in front of it
	typedef struct {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		int                        gap;
	} list_req_t;

	// one result as seen on the ports
	typedef struct {
		logic                      ok;
		logic [FIDX_W-1:0]         found_index;
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        count;
	} list_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	op_t                       op = OP_INSERT;
	logic signed [VALUE_W-1:0] value = '0;
	logic [POS_W-1:0]          position = '0;
	logic                      done;
	logic                      ok;
	logic [FIDX_W-1:0]         found_index;
	logic signed [VALUE_W-1:0] read_value;
	logic [COUNT_W-1:0]        count;

	// requests waiting to be driven, results waiting to be seen
	list_req_t    pending_requests[$];
	list_result_t awaited_results[$];

	// shadow of the list contents
	logic signed [VALUE_W-1:0] list_store [DEPTH];
	int                        list_len = 0;

	// value pool so that locates hit and duplicates show up
	logic signed [VALUE_W-1:0] value_pool [12];

	// driver state
	list_req_t cur_req;
	logic      staged = 1'b0;
	logic      presenting = 1'b0;
	int        hold = 0;
	logic      req_taken = 1'b0;

	int mismatch_count = 0;

	array_list_insert_delete_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.value       (value),
		.position    (position),
		.done        (done),
		.ok          (ok),
		.found_index (found_index),
		.read_value  (read_value),
		.count       (count)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// one line per mismatch, printing capped so a broken block stays readable
	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		mismatch_count++;
	endtask

	// apply one request to the shadow list and work out its result
	function automatic list_result_t list_apply(input list_req_t req);
		list_result_t res;
		int           i;
		int           slot;
		res.ok          = 1'b0;
		res.found_index = '0;
		res.read_value  = '0;
		case (req.op)
			OP_INSERT: begin
				// full list refuses, otherwise the position is clamped to the tail
				if (list_len < DEPTH) begin
					slot = (int'(req.position) > list_len) ? list_len : int'(req.position);
					for (i = list_len; i > slot; i--) begin
						list_store[i] = list_store[i - 1];
					end
					list_store[slot] = req.value;
					list_len++;
					res.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				// at or past the tail (empty list included) nothing moves
				if (int'(req.position) < list_len) begin
					for (i = int'(req.position); i < list_len - 1; i++) begin
						list_store[i] = list_store[i + 1];
					end
					list_len--;
					res.ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				// lowest matching slot wins
				for (i = 0; i < list_len; i++) begin
					if (!res.ok && list_store[i] == req.value) begin
						res.ok          = 1'b1;
						res.found_index = i[FIDX_W-1:0];
					end
				end
			end
			default: begin
				if (int'(req.position) < list_len) begin
					res.ok         = 1'b1;
					res.read_value = list_store[int'(req.position)];
				end else begin
					// invalid position reads back the most negative value
					res.read_value = {1'b1, {(VALUE_W-1){1'b0}}};
				end
			end
		endcase
		res.count = list_len[COUNT_W-1:0];
		return res;
	endfunction

	task automatic add_request(input op_t o, input logic [VALUE_W-1:0] v,
	                           input logic [POS_W-1:0] p, input int g);
		list_req_t r;
		r.op       = o;
		r.value    = v;
		r.position = p;
		r.gap      = g;
		pending_requests.push_back(r);
	endtask

	// driver: fields change on the falling edge; start stays high back to back
	// when the next request has no gap, so it gets a single assignment per step
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// the transaction on the ports was taken at the last rising edge
			if (presenting && req_taken) begin
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (!staged && pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					hold    = cur_req.gap;
					staged  = 1'b1;
				end
				if (staged) begin
					if (hold > 0) begin
						hold--;
					end else begin
						op         <= cur_req.op;
						value      <= cur_req.value;
						position   <= cur_req.position;
						presenting = 1'b1;
						staged     = 1'b0;
					end
				end
			end
			start <= presenting;
		end
	end

	// monitor: check a finished transaction first, then predict the one accepted
	// at this same edge, since a new start can land in the result cycle
	always @(posedge clk) begin
		list_result_t exp_res;
		list_req_t    acc_req;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing awaited (count %0d)", count));
				end else begin
					exp_res = awaited_results.pop_front();
					if (ok !== exp_res.ok) begin
						report_mismatch($sformatf("ok got %0b expected %0b", ok, exp_res.ok));
					end
					if (found_index !== exp_res.found_index) begin
						report_mismatch($sformatf("found_index got %0d expected %0d",
							found_index, exp_res.found_index));
					end
					if (read_value !== exp_res.read_value) begin
						report_mismatch($sformatf("read_value got %h expected %h",
							read_value, exp_res.read_value));
					end
					if (count !== exp_res.count) begin
						report_mismatch($sformatf("count got %0d expected %0d",
							count, exp_res.count));
					end
				end
			end
			if (start && !busy) begin
				acc_req.op       = op;
				acc_req.value    = value;
				acc_req.position = position;
				acc_req.gap      = 0;
				awaited_results.push_back(list_apply(acc_req));
			end
			req_taken <= start && !busy;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int n;
		int k;
		int bias;
		int roll;
		int fast;
		op_t                       r_op;
		logic signed [VALUE_W-1:0] r_val;
		logic [POS_W-1:0]          r_pos;

		value_pool[0] = 32'h7fff_ffff;
		value_pool[1] = 32'h8000_0000;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (k = 4; k < 12; k++) begin
			value_pool[k] = $urandom;
		end

		// directed: empty-list corner cases first
		add_request(OP_RETRIEVE, 32'h0, 4'd0, 0);
		add_request(OP_DELETE, 32'h0, 4'd0, 0);
		add_request(OP_LOCATE, 32'h0, 4'd0, $urandom_range(0, 9));
		// insert far past the tail gets clamped
		add_request(OP_INSERT, 32'h7fff_ffff, 4'd15, 0);
		add_request(OP_INSERT, 32'h8000_0000, 4'd0, 0);
		add_request(OP_INSERT, 32'h0000_0000, 4'd1, $urandom_range(0, 9));
		add_request(OP_INSERT, 32'hffff_ffff, 4'd9, 0);
		add_request(OP_INSERT, 32'h5a5a_a5a5, 4'd2, 0);
		add_request(OP_INSERT, 32'hffff_ffff, 4'd0, 0);
		add_request(OP_INSERT, 32'h1234_5678, 4'd3, $urandom_range(0, 9));
		add_request(OP_INSERT, 32'ha5a5_5a5a, 4'd7, 0);
		// list is full now: insert refused
		add_request(OP_INSERT, 32'h0bad_f00d, 4'd4, 0);
		// duplicate value: lowest slot reported, then a miss
		add_request(OP_LOCATE, 32'hffff_ffff, 4'd0, 0);
		add_request(OP_LOCATE, 32'h0bad_f00d, 4'd15, 0);
		add_request(OP_LOCATE, 32'ha5a5_5a5a, 4'd0, 0);
		add_request(OP_RETRIEVE, 32'h0, 4'd7, 0);
		add_request(OP_RETRIEVE, 32'h0, 4'd8, $urandom_range(0, 9));
		add_request(OP_RETRIEVE, 32'h0, 4'd15, 0);
		// delete at the count fails, then head, tail and middle
		add_request(OP_DELETE, 32'h0, 4'd8, 0);
		add_request(OP_DELETE, 32'h0, 4'd15, 0);
		add_request(OP_DELETE, 32'h0, 4'd0, 0);
		add_request(OP_DELETE, 32'h0, 4'd6, 0);
		add_request(OP_DELETE, 32'h0, 4'd2, $urandom_range(0, 9));
		add_request(OP_RETRIEVE, 32'h0, 4'd2, 0);
		add_request(OP_LOCATE, 32'h8000_0000, 4'd0, 0);

		// random: blocks that lean toward growing, shrinking or neither, so the
		// count sweeps empty to full; some blocks run with no idling at all
		n = 0;
		while (n < RANDOM_REQS) begin
			bias = $urandom_range(0, 2);
			fast = ($urandom_range(0, 3) == 0);
			for (k = 0; k < 40 && n < RANDOM_REQS; k++) begin
				roll = $urandom_range(0, 99);
				case (bias)
					0:       r_op = (roll < 55) ? OP_INSERT : (roll < 70) ? OP_DELETE :
					                (roll < 85) ? OP_LOCATE : OP_RETRIEVE;
					1:       r_op = (roll < 15) ? OP_INSERT : (roll < 70) ? OP_DELETE :
					                (roll < 85) ? OP_LOCATE : OP_RETRIEVE;
					default: r_op = op_t'($urandom_range(0, 3));
				endcase
				r_val = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 11)]
				                                   : $urandom;
				r_pos = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, DEPTH))
				                                    : POS_W'($urandom_range(0, 15));
				add_request(r_op, r_val, r_pos, fast ? 0 : $urandom_range(0, 9));
				n++;
			end
		end

		repeat (RESET_CYCS) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: every transaction accepted and every result seen
		while (pending_requests.size() > 0 || staged || presenting ||
		       awaited_results.size() > 0) begin
			@(posedge clk);
		end
		// stray strobes after the last result still get caught by the monitor
		repeat (2 * DEPTH + 8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/alids_pkg.sv
rtl/alids_ram.sv
rtl/array_list_insert_delete_search.sv
verif/array_list_insert_delete_search_tb.sv
